FILE: rtl/rational_basis_derivative_eval_defines.svh
// ----------------------------------------------------------------------------
// rational_basis_derivative_eval_defines
// assertion macros for the rational basis block
// ----------------------------------------------------------------------------
`ifndef RATIONAL_BASIS_DERIVATIVE_EVAL_DEFINES_SVH
`define RATIONAL_BASIS_DERIVATIVE_EVAL_DEFINES_SVH

// property must hold at every clock edge outside reset
`define RBD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// antecedent implies consequent in the following cycle
`define RBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/rbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_pkg
// shared types and constants of the rational basis derivative block
// ----------------------------------------------------------------------------
package rbd_pkg;

  localparam int unsigned Points   = 64;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned FxW      = 32;
  localparam int unsigned StoreW   = 6 * FxW;
  localparam int unsigned OpCntW   = 5;

  localparam logic [1:0] StatusOk     = 2'd0;
  localparam logic [1:0] StatusBadQ   = 2'd1;
  localparam logic [1:0] StatusNoPt   = 2'd2;
  localparam logic [1:0] StatusSat    = 2'd3;

  localparam logic ReqLoad = 1'b0;
  localparam logic ReqEval = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_MUL,
    ST_WR,
    ST_OUT
  } state_e;

  // operand selects for the shared multiplier
  typedef enum logic [3:0] {
    SEL_V, SEL_GX, SEL_GY, SEL_HXX, SEL_HXY, SEL_HYY, SEL_W,
    SEL_INV, SEL_INV2, SEL_TWOINV, SEL_SX, SEL_SY,
    SEL_TXX, SEL_TXY, SEL_TYY, SEL_ACC
  } opsel_e;

  typedef enum logic [2:0] {
    ACC_NONE,  // product only to dst, no acc change
    ACC_LOAD,  // acc = +p
    ACC_ADD,   // acc += p
    ACC_SUB,   // acc -= p
    ACC_TMP    // no acc change
  } accop_e;

  typedef enum logic [3:0] {
    DST_NONE, DST_INV2, DST_SX, DST_SY, DST_TMP,
    DST_R0, DST_R1, DST_R2, DST_R3, DST_R4, DST_R5,
    DST_TXX, DST_TXY, DST_TYY
  } dst_e;

  typedef struct packed {
    logic   latch_in;
    logic   div_start;
    logic   rd_en;
    logic   wr_en;
    logic   mul_en;
    opsel_e sel_a;
    opsel_e sel_b;
    accop_e acc_op;
    dst_e   dst;
    logic   acc_clamp;   // saturate acc into acc before use
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic req_eval;
    logic idx_bad;
    logic q_bad;
    logic loaded;
    logic div_done;
  } sts_t;

  function automatic logic [FxW-1:0] sat32(input logic signed [65:0] v, output logic hit);
    logic signed [65:0] mx;
    logic signed [65:0] mn;
    begin
      mx = 66'sd2147483647;
      mn = -66'sd2147483648;
      hit = 1'b0;
      if (v > mx) begin
        hit = 1'b1;
        sat32 = 32'h7fffffff;
      end else if (v < mn) begin
        hit = 1'b1;
        sat32 = 32'h80000000;
      end else begin
        sat32 = v[FxW-1:0];
      end
    end
  endfunction

endpackage

FILE: rtl/rbd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_in_if / rbd_out_if
// valid-ready channels for request and result beats
// ----------------------------------------------------------------------------
interface rbd_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [5:0]  point_index;
  logic signed [31:0] weight;
  logic signed [31:0] value_term;
  logic signed [31:0] first_x;
  logic signed [31:0] first_y;
  logic signed [31:0] second_xx;
  logic signed [31:0] second_xy;
  logic signed [31:0] second_yy;
  modport source (output valid, req_type, point_index, weight, value_term, first_x, first_y,
                  second_xx, second_xy, second_yy, input ready);
  modport sink (input valid, req_type, point_index, weight, value_term, first_x, first_y,
                second_xx, second_xy, second_yy, output ready);
endinterface

interface rbd_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] rational_value;
  logic signed [31:0] rational_dx;
  logic signed [31:0] rational_dy;
  logic signed [31:0] rational_dxx;
  logic signed [31:0] rational_dxy;
  logic signed [31:0] rational_dyy;
  logic [1:0]  status;
  modport source (output valid, rational_value, rational_dx, rational_dy, rational_dxx,
                  rational_dxy, rational_dyy, status, input ready);
  modport sink (input valid, rational_value, rational_dx, rational_dy, rational_dxx,
                rational_dxy, rational_dyy, status, output ready);
endinterface

FILE: rtl/rational_basis_derivative_eval.sv
`timescale 1ns / 1ps
// sequence: load runs check, divider, multiplier steps, store write and result;
//   evaluate runs check, store read, multiplier steps and result; a rejected or
//   unloaded beat goes from the check straight to the result
// throughput: one beat at a time; the next beat is taken the cycle after the result leaves
// reset: asynchronous active low; clears the sequencer and the loaded flags,
//   the point store keeps its contents and its read data is only used behind a loaded flag
// ----------------------------------------------------------------------------
// rational_basis_derivative_eval
// nurbs rational basis value, gradient and hessian from b-spline data
// ----------------------------------------------------------------------------
module rational_basis_derivative_eval (
  input  logic     clk_i,
  input  logic     rst_ni,
  rbd_in_if.sink   in_if,
  rbd_out_if.source out_if
);
  rbd_pkg::cmd_t cmd;
  rbd_pkg::sts_t sts;
  logic [191:0]  res;
  logic [1:0]    status_sel;
  logic [1:0]    status;

  // sequencer drives the handshake and the microprogram
  rbd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_ready_o   (in_if.ready),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .status_sel_o (status_sel)
  );

  // datapath holds the latched beat, the point store and the multiplier
  rbd_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_if        (in_if),
    .res_o        (res),
    .status_o     (status),
    .status_sel_i (status_sel)
  );

  // result fields held stable in the datapath until the beat is taken
  assign out_if.rational_value = res[31:0];
  assign out_if.rational_dx    = res[63:32];
  assign out_if.rational_dy    = res[95:64];
  assign out_if.rational_dxx   = res[127:96];
  assign out_if.rational_dxy   = res[159:128];
  assign out_if.rational_dyy   = res[191:160];
  assign out_if.status         = status;
endmodule

FILE: rtl/rbd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module rbd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: rtl/rbd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_div
// restoring divider for round(2^32 / q), one quotient bit per cycle
// ----------------------------------------------------------------------------
module rbd_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] q_i,
  output logic        done_o,
  output logic [32:0] quot_o
);
  // dividend 2^32 + q/2, at most 34 bits
  logic [33:0] num_q, num_d;
  logic [32:0] rem_q, rem_d;
  logic [33:0] quo_q, quo_d;
  logic [31:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [33:0] trial;

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = '0;
    if (start_i) begin
      num_d  = 34'h100000000 + {3'b000, q_i[31:1]};
      den_d  = q_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = 6'd34;
      busy_d = 1'b1;
    end else if (busy_q) begin
      trial = {rem_q, num_q[33]};
      num_d = {num_q[32:0], 1'b0};
      if (trial >= {2'b00, den_q}) begin
        rem_d = 33'(trial - {2'b00, den_q});
        quo_d = {quo_q[32:0], 1'b1};
      end else begin
        rem_d = trial[32:0];
        quo_d = {quo_q[32:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  // quotient below 2^33 since q >= 1
  assign quot_o = quo_q[32:0];
endmodule

FILE: rtl/rbd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_datapath
// input latch, point store, reciprocal unit, shared multiplier and accumulator
// ----------------------------------------------------------------------------
`include "rational_basis_derivative_eval_defines.svh"
module rbd_datapath (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  rbd_pkg::cmd_t cmd_i,
  output rbd_pkg::sts_t sts_o,
  rbd_in_if.sink        in_if,
  output logic [191:0]  res_o,
  output logic [1:0]    status_o,
  input  logic [1:0]    status_sel_i
);
  logic                req_q;
  logic [5:0]          idx_q;
  logic signed [31:0]  w_q, v_q, gx_q, gy_q, hxx_q, hxy_q, hyy_q;
  logic [rbd_pkg::Points-1:0] loaded_q;
  logic signed [31:0]  inv_q, inv2_q, twoinv_q, sx_q, sy_q, txx_q, txy_q, tyy_q;
  logic signed [31:0]  r_q [6];
  logic signed [65:0]  acc_q;
  logic                sat_q;
  logic                div_done;
  logic [32:0]         quot;
  logic [rbd_pkg::StoreW-1:0] wdata, rdata;
  logic signed [31:0]  a_op, b_op, acc_sat;
  logic signed [63:0]  prod;
  logic signed [65:0]  shifted;
  logic [31:0]         p32;
  logic                p_hit, acc_hit, inv_hit;
  logic [31:0]         inv_sat;
  logic [31:0]         twoinv_sat;
  logic                twoinv_hit;

  function automatic logic signed [31:0] pick(
    input rbd_pkg::opsel_e s, input logic signed [31:0] v, gx, gy, hxx, hxy, hyy, w,
    inv, inv2, twoinv, sx, sy, txx, txy, tyy, acc);
    begin
      case (s)
        rbd_pkg::SEL_V:      pick = v;
        rbd_pkg::SEL_GX:     pick = gx;
        rbd_pkg::SEL_GY:     pick = gy;
        rbd_pkg::SEL_HXX:    pick = hxx;
        rbd_pkg::SEL_HXY:    pick = hxy;
        rbd_pkg::SEL_HYY:    pick = hyy;
        rbd_pkg::SEL_W:      pick = w;
        rbd_pkg::SEL_INV:    pick = inv;
        rbd_pkg::SEL_INV2:   pick = inv2;
        rbd_pkg::SEL_TWOINV: pick = twoinv;
        rbd_pkg::SEL_SX:     pick = sx;
        rbd_pkg::SEL_SY:     pick = sy;
        rbd_pkg::SEL_TXX:    pick = txx;
        rbd_pkg::SEL_TXY:    pick = txy;
        rbd_pkg::SEL_TYY:    pick = tyy;
        default:             pick = acc;
      endcase
    end
  endfunction

  rbd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .q_i     (v_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  rbd_ram #(.Width(rbd_pkg::StoreW), .Depth(rbd_pkg::Points)) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .re_i    (cmd_i.rd_en),
    .addr_i  (idx_q),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  assign wdata = {inv_q, sx_q, sy_q, txx_q, txy_q, tyy_q};

  // accumulator saturated to a fixed-point operand
  always_comb begin
    acc_sat = $signed(rbd_pkg::sat32(acc_q, acc_hit));
  end

  assign a_op = pick(cmd_i.sel_a, v_q, gx_q, gy_q, hxx_q, hxy_q, hyy_q, w_q, inv_q, inv2_q,
                     twoinv_q, sx_q, sy_q, txx_q, txy_q, tyy_q, acc_sat);
  assign b_op = pick(cmd_i.sel_b, v_q, gx_q, gy_q, hxx_q, hxy_q, hyy_q, w_q, inv_q, inv2_q,
                     twoinv_q, sx_q, sy_q, txx_q, txy_q, tyy_q, acc_sat);
  assign prod    = a_op * b_op;
  // arithmetic shift is floor
  assign shifted = (66'(prod) + 66'sd32768) >>> 16;

  always_comb begin
    p32 = rbd_pkg::sat32(shifted, p_hit);
  end

  always_comb begin
    inv_sat    = rbd_pkg::sat32($signed({33'b0, quot}), inv_hit);
    twoinv_sat = rbd_pkg::sat32($signed({33'b0, inv_sat, 1'b0}), twoinv_hit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= '0;
      sat_q    <= 1'b0;
    end else begin
      if (cmd_i.latch_in) begin
        sat_q <= 1'b0;
      end else begin
        if (div_done && (inv_hit || twoinv_hit)) sat_q <= 1'b1;
        if (cmd_i.mul_en && p_hit) sat_q <= 1'b1;
        if (cmd_i.acc_clamp && acc_hit) sat_q <= 1'b1;
      end
      if (cmd_i.wr_en) loaded_q[idx_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      req_q <= in_if.req_type;
      idx_q <= in_if.point_index;
      w_q   <= in_if.weight;
      v_q   <= in_if.value_term;
      gx_q  <= in_if.first_x;
      gy_q  <= in_if.first_y;
      hxx_q <= in_if.second_xx;
      hxy_q <= in_if.second_xy;
      hyy_q <= in_if.second_yy;
      for (int k = 0; k < 6; k++) r_q[k] <= '0;
    end
    if (div_done) begin
      inv_q    <= inv_sat;
      twoinv_q <= twoinv_sat;
    end
    if (cmd_i.acc_clamp) acc_q <= 66'(acc_sat);
    if (cmd_i.mul_en) begin
      case (cmd_i.acc_op)
        rbd_pkg::ACC_LOAD: acc_q <= 66'($signed(p32));
        rbd_pkg::ACC_ADD:  acc_q <= acc_q + 66'($signed(p32));
        rbd_pkg::ACC_SUB:  acc_q <= acc_q - 66'($signed(p32));
        default: ;
      endcase
      case (cmd_i.dst)
        rbd_pkg::DST_INV2: inv2_q <= p32;
        rbd_pkg::DST_SX:   sx_q   <= p32;
        rbd_pkg::DST_SY:   sy_q   <= p32;
        rbd_pkg::DST_R0:   r_q[0] <= p32;
        rbd_pkg::DST_R1:   r_q[1] <= p32;
        rbd_pkg::DST_R2:   r_q[2] <= p32;
        rbd_pkg::DST_R3:   r_q[3] <= p32;
        rbd_pkg::DST_R4:   r_q[4] <= p32;
        rbd_pkg::DST_R5:   r_q[5] <= p32;
        default: ;
      endcase
    end
    // stored t terms come from the saturated accumulator
    if (cmd_i.acc_clamp) begin
      case (cmd_i.dst)
        rbd_pkg::DST_TXX: txx_q <= acc_sat;
        rbd_pkg::DST_TXY: txy_q <= acc_sat;
        rbd_pkg::DST_TYY: tyy_q <= acc_sat;
        default: ;
      endcase
    end
    // store data arrives the cycle after the read
    if (cmd_i.out_load) begin
      {inv_q, sx_q, sy_q, txx_q, txy_q, tyy_q} <= rdata;
    end
  end

  assign sts_o.req_eval = req_q;
  assign sts_o.idx_bad  = 1'b0;
  assign sts_o.q_bad    = (v_q <= 32'sd0);
  assign sts_o.loaded   = loaded_q[idx_q];
  assign sts_o.div_done = div_done;

  assign res_o = {r_q[5], r_q[4], r_q[3], r_q[2], r_q[1], r_q[0]};
  always_comb begin
    case (status_sel_i)
      rbd_pkg::StatusBadQ: status_o = rbd_pkg::StatusBadQ;
      rbd_pkg::StatusNoPt: status_o = rbd_pkg::StatusNoPt;
      default:             status_o = sat_q ? rbd_pkg::StatusSat : rbd_pkg::StatusOk;
    endcase
  end

  `RBD_ASSERT_NEXT(a_wr_marks, clk_i, rst_ni, cmd_i.wr_en, loaded_q[$past(idx_q)])
  `RBD_ASSERT_NEXT(a_latch_clears_sat, clk_i, rst_ni, cmd_i.latch_in, !sat_q)
  `RBD_ASSERT(a_no_rw, clk_i, rst_ni, !(cmd_i.wr_en && cmd_i.rd_en))
  `RBD_ASSERT(a_wr_needs_good_q, clk_i, rst_ni, !cmd_i.wr_en || !sts_o.q_bad)
endmodule

FILE: rtl/rbd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_ctrl
// sequencer: microprogram of multiplier steps for load and evaluate beats
// ----------------------------------------------------------------------------
`include "rational_basis_derivative_eval_defines.svh"
module rbd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  rbd_pkg::sts_t sts_i,
  output rbd_pkg::cmd_t cmd_o,
  output logic [1:0]    status_sel_o
);
  rbd_pkg::state_e state_q, state_d;
  logic [4:0] step_q, step_d;
  logic [1:0] ssel_q, ssel_d;
  logic       last_step;

  typedef struct packed {
    rbd_pkg::opsel_e a;
    rbd_pkg::opsel_e b;
    rbd_pkg::accop_e op;
    rbd_pkg::dst_e   dst;
    logic            clamp;
  } uop_t;

  // load program: inv2, sx, sy, then t = (s*g)*2inv - h*inv2 per entry
  function automatic uop_t load_uop(input logic [4:0] s);
    uop_t u;
    begin
      u = '{rbd_pkg::SEL_V, rbd_pkg::SEL_V, rbd_pkg::ACC_NONE, rbd_pkg::DST_NONE, 1'b0};
      case (s)
        5'd0:  u = '{rbd_pkg::SEL_INV, rbd_pkg::SEL_INV, rbd_pkg::ACC_NONE, rbd_pkg::DST_INV2, 1'b0};
        5'd1:  u = '{rbd_pkg::SEL_INV2, rbd_pkg::SEL_GX, rbd_pkg::ACC_NONE, rbd_pkg::DST_SX, 1'b0};
        5'd2:  u = '{rbd_pkg::SEL_INV2, rbd_pkg::SEL_GY, rbd_pkg::ACC_NONE, rbd_pkg::DST_SY, 1'b0};
        5'd3:  u = '{rbd_pkg::SEL_SX, rbd_pkg::SEL_GX, rbd_pkg::ACC_LOAD, rbd_pkg::DST_NONE, 1'b0};
        5'd4:  u = '{rbd_pkg::SEL_ACC, rbd_pkg::SEL_TWOINV, rbd_pkg::ACC_LOAD, rbd_pkg::DST_NONE, 1'b0};
        5'd5:  u = '{rbd_pkg::SEL_HXX, rbd_pkg::SEL_INV2, rbd_pkg::ACC_SUB, rbd_pkg::DST_NONE, 1'b0};
        5'd6:  u = '{rbd_pkg::SEL_V, rbd_pkg::SEL_V, rbd_pkg::ACC_NONE, rbd_pkg::DST_TXX, 1'b1};
        5'd7:  u = '{rbd_pkg::SEL_SX, rbd_pkg::SEL_GY, rbd_pkg::ACC_LOAD, rbd_pkg::DST_NONE, 1'b0};
        5'd8:  u = '{rbd_pkg::SEL_ACC, rbd_pkg::SEL_TWOINV, rbd_pkg::ACC_LOAD, rbd_pkg::DST_NONE, 1'b0};
        5'd9:  u = '{rbd_pkg::SEL_HXY, rbd_pkg::SEL_INV2, rbd_pkg::ACC_SUB, rbd_pkg::DST_NONE, 1'b0};
        5'd10: u = '{rbd_pkg::SEL_V, rbd_pkg::SEL_V, rbd_pkg::ACC_NONE, rbd_pkg::DST_TXY, 1'b1};
        5'd11: u = '{rbd_pkg::SEL_SY, rbd_pkg::SEL_GY, rbd_pkg::ACC_LOAD, rbd_pkg::DST_NONE, 1'b0};
        5'd12: u = '{rbd_pkg::SEL_ACC, rbd_pkg::SEL_TWOINV, rbd_pkg::ACC_LOAD, rbd_pkg::DST_NONE, 1'b0};
        5'd13: u = '{rbd_pkg::SEL_HYY, rbd_pkg::SEL_INV2, rbd_pkg::ACC_SUB, rbd_pkg::DST_NONE, 1'b0};
        5'd14: u = '{rbd_pkg::SEL_V, rbd_pkg::SEL_V, rbd_pkg::ACC_NONE, rbd_pkg::DST_TYY, 1'b1};
        default: ;
      endcase
      load_uop = u;
    end
  endfunction

  // evaluate program; each result is acc*w, a clamp step first saturates acc for the derivatives
  function automatic uop_t eval_uop(input logic [4:0] s);
    uop_t u;
    begin
      u = '{rbd_pkg::SEL_V, rbd_pkg::SEL_V, rbd_pkg::ACC_NONE, rbd_pkg::DST_NONE, 1'b0};
      case (s)
        5'd0:  u = '{rbd_pkg::SEL_V, rbd_pkg::SEL_INV, rbd_pkg::ACC_LOAD, rbd_pkg::DST_NONE, 1'b0};
        5'd1:  u = '{rbd_pkg::SEL_ACC, rbd_pkg::SEL_W, rbd_pkg::ACC_NONE, rbd_pkg::DST_R0, 1'b0};
        5'd2:  u = '{rbd_pkg::SEL_GX, rbd_pkg::SEL_INV, rbd_pkg::ACC_LOAD, rbd_pkg::DST_NONE, 1'b0};
        5'd3:  u = '{rbd_pkg::SEL_V, rbd_pkg::SEL_SX, rbd_pkg::ACC_SUB, rbd_pkg::DST_NONE, 1'b0};
        5'd4:  u = '{rbd_pkg::SEL_V, rbd_pkg::SEL_V, rbd_pkg::ACC_NONE, rbd_pkg::DST_NONE, 1'b1};
        5'd5:  u = '{rbd_pkg::SEL_ACC, rbd_pkg::SEL_W, rbd_pkg::ACC_NONE, rbd_pkg::DST_R1, 1'b0};
        5'd6:  u = '{rbd_pkg::SEL_GY, rbd_pkg::SEL_INV, rbd_pkg::ACC_LOAD, rbd_pkg::DST_NONE, 1'b0};
        5'd7:  u = '{rbd_pkg::SEL_V, rbd_pkg::SEL_SY, rbd_pkg::ACC_SUB, rbd_pkg::DST_NONE, 1'b0};
        5'd8:  u = '{rbd_pkg::SEL_V, rbd_pkg::SEL_V, rbd_pkg::ACC_NONE, rbd_pkg::DST_NONE, 1'b1};
        5'd9:  u = '{rbd_pkg::SEL_ACC, rbd_pkg::SEL_W, rbd_pkg::ACC_NONE, rbd_pkg::DST_R2, 1'b0};
        5'd10: u = '{rbd_pkg::SEL_HXX, rbd_pkg::SEL_INV, rbd_pkg::ACC_LOAD, rbd_pkg::DST_NONE, 1'b0};
        5'd11: u = '{rbd_pkg::SEL_GX, rbd_pkg::SEL_SX, rbd_pkg::ACC_SUB, rbd_pkg::DST_NONE, 1'b0};
        5'd12: u = '{rbd_pkg::SEL_GX, rbd_pkg::SEL_SX, rbd_pkg::ACC_SUB, rbd_pkg::DST_NONE, 1'b0};
        5'd13: u = '{rbd_pkg::SEL_V, rbd_pkg::SEL_TXX, rbd_pkg::ACC_ADD, rbd_pkg::DST_NONE, 1'b0};
        5'd14: u = '{rbd_pkg::SEL_V, rbd_pkg::SEL_V, rbd_pkg::ACC_NONE, rbd_pkg::DST_NONE, 1'b1};
        5'd15: u = '{rbd_pkg::SEL_ACC, rbd_pkg::SEL_W, rbd_pkg::ACC_NONE, rbd_pkg::DST_R3, 1'b0};
        5'd16: u = '{rbd_pkg::SEL_HXY, rbd_pkg::SEL_INV, rbd_pkg::ACC_LOAD, rbd_pkg::DST_NONE, 1'b0};
        5'd17: u = '{rbd_pkg::SEL_GX, rbd_pkg::SEL_SY, rbd_pkg::ACC_SUB, rbd_pkg::DST_NONE, 1'b0};
        5'd18: u = '{rbd_pkg::SEL_GY, rbd_pkg::SEL_SX, rbd_pkg::ACC_SUB, rbd_pkg::DST_NONE, 1'b0};
        5'd19: u = '{rbd_pkg::SEL_V, rbd_pkg::SEL_TXY, rbd_pkg::ACC_ADD, rbd_pkg::DST_NONE, 1'b0};
        5'd20: u = '{rbd_pkg::SEL_V, rbd_pkg::SEL_V, rbd_pkg::ACC_NONE, rbd_pkg::DST_NONE, 1'b1};
        5'd21: u = '{rbd_pkg::SEL_ACC, rbd_pkg::SEL_W, rbd_pkg::ACC_NONE, rbd_pkg::DST_R4, 1'b0};
        5'd22: u = '{rbd_pkg::SEL_HYY, rbd_pkg::SEL_INV, rbd_pkg::ACC_LOAD, rbd_pkg::DST_NONE, 1'b0};
        5'd23: u = '{rbd_pkg::SEL_GY, rbd_pkg::SEL_SY, rbd_pkg::ACC_SUB, rbd_pkg::DST_NONE, 1'b0};
        5'd24: u = '{rbd_pkg::SEL_GY, rbd_pkg::SEL_SY, rbd_pkg::ACC_SUB, rbd_pkg::DST_NONE, 1'b0};
        5'd25: u = '{rbd_pkg::SEL_V, rbd_pkg::SEL_TYY, rbd_pkg::ACC_ADD, rbd_pkg::DST_NONE, 1'b0};
        5'd26: u = '{rbd_pkg::SEL_V, rbd_pkg::SEL_V, rbd_pkg::ACC_NONE, rbd_pkg::DST_NONE, 1'b1};
        5'd27: u = '{rbd_pkg::SEL_ACC, rbd_pkg::SEL_W, rbd_pkg::ACC_NONE, rbd_pkg::DST_R5, 1'b0};
        default: ;
      endcase
      eval_uop = u;
    end
  endfunction

  uop_t uop;

  assign uop = sts_i.req_eval ? eval_uop(step_q) : load_uop(step_q);
  assign last_step = sts_i.req_eval ? (step_q == 5'd27) : (step_q == 5'd14);

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    ssel_d  = ssel_q;
    case (state_q)
      rbd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = rbd_pkg::ST_RD;
          step_d  = '0;
          ssel_d  = rbd_pkg::StatusOk;
        end
      end
      rbd_pkg::ST_RD: begin
        if (sts_i.req_eval) begin
          if (!sts_i.loaded) begin
            ssel_d  = rbd_pkg::StatusNoPt;
            state_d = rbd_pkg::ST_OUT;
          end else begin
            state_d = rbd_pkg::ST_WR;  // wait for the registered store data
          end
        end else if (sts_i.q_bad) begin
          ssel_d  = rbd_pkg::StatusBadQ;
          state_d = rbd_pkg::ST_OUT;
        end else begin
          state_d = rbd_pkg::ST_DIV;
        end
      end
      rbd_pkg::ST_WR: begin
        // eval: data captured; load: store written
        state_d = sts_i.req_eval ? rbd_pkg::ST_MUL : rbd_pkg::ST_OUT;
      end
      rbd_pkg::ST_DIV: begin
        if (sts_i.div_done) state_d = rbd_pkg::ST_MUL;
      end
      rbd_pkg::ST_MUL: begin
        step_d = step_q + 5'd1;
        if (last_step) state_d = sts_i.req_eval ? rbd_pkg::ST_OUT : rbd_pkg::ST_WR;
      end
      rbd_pkg::ST_OUT: begin
        if (out_ready_i) state_d = rbd_pkg::ST_IDLE;
      end
      default: state_d = rbd_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    cmd_o.sel_a  = uop.a;
    cmd_o.sel_b  = uop.b;
    cmd_o.acc_op = rbd_pkg::ACC_NONE;
    cmd_o.dst    = rbd_pkg::DST_NONE;
    in_ready_o   = 1'b0;
    out_valid_o  = 1'b0;
    case (state_q)
      rbd_pkg::ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.latch_in = in_valid_i;
      end
      rbd_pkg::ST_RD: begin
        cmd_o.rd_en     = sts_i.req_eval;
        cmd_o.div_start = !sts_i.req_eval && !sts_i.q_bad;
      end
      rbd_pkg::ST_WR: begin
        cmd_o.wr_en    = !sts_i.req_eval;
        cmd_o.out_load = sts_i.req_eval;
      end
      rbd_pkg::ST_MUL: begin
        cmd_o.mul_en    = !uop.clamp;
        cmd_o.acc_op    = uop.op;
        cmd_o.dst       = uop.dst;
        cmd_o.acc_clamp = uop.clamp;
      end
      rbd_pkg::ST_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rbd_pkg::ST_IDLE;
      step_q  <= '0;
      ssel_q  <= rbd_pkg::StatusOk;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      ssel_q  <= ssel_d;
    end
  end

  assign status_sel_o = ssel_q;

  `RBD_ASSERT(a_one_side, clk_i, rst_ni, !(in_ready_o && out_valid_o))
  `RBD_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, in_ready_o && in_valid_i,
                   state_q == rbd_pkg::ST_RD)
  `RBD_ASSERT(a_step_range, clk_i, rst_ni, step_q <= 5'd28)
endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks rational basis value, gradient and hessian beats against a local
// q16.16 predictor, under random idling on both channels and back-pressure
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned WatchLimit = 20000;

  typedef struct packed {
    logic        req_type;
    logic [5:0]  point_index;
    logic [31:0] weight;
    logic [31:0] value_term;
    logic [31:0] first_x;
    logic [31:0] first_y;
    logic [31:0] second_xx;
    logic [31:0] second_xy;
    logic [31:0] second_yy;
  } request_t;

  typedef struct packed {
    logic [31:0] rational_value;
    logic [31:0] rational_dx;
    logic [31:0] rational_dy;
    logic [31:0] rational_dxx;
    logic [31:0] rational_dxy;
    logic [31:0] rational_dyy;
    logic [1:0]  status;
  } answer_t;

  // predictor of the block: per-point weight terms and arithmetic
  class rational_scoreboard;
    logic [31:0] inv_q   [rbd_pkg::Points];
    logic [31:0] grad_sx [rbd_pkg::Points];
    logic [31:0] grad_sy [rbd_pkg::Points];
    logic [31:0] term_xx [rbd_pkg::Points];
    logic [31:0] term_xy [rbd_pkg::Points];
    logic [31:0] term_yy [rbd_pkg::Points];
    bit          loaded  [rbd_pkg::Points];
    bit          sat_seen;
    answer_t     pending_answers[$];
    int          mismatch_cnt;

    function void clear();
      foreach (loaded[i]) loaded[i] = 0;
      pending_answers.delete();
      mismatch_cnt = 0;
    endfunction

    function longint clamp(longint v);
      if (v > 64'sd2147483647) begin
        sat_seen = 1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        sat_seen = 1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    // rounded q16.16 product, >>> floors
    function longint qmul(longint a, longint b);
      return clamp((a * b + 32768) >>> 16);
    endfunction

    function longint sx(logic [31:0] v);
      return longint'($signed(v));
    endfunction

    function void note_request(request_t rq);
      answer_t a;
      longint  w, v, gx, gy, hxx, hxy, hyy;
      longint  inv, inv2, two_inv, s_x, s_y, t;
      int      p;
      a = '0;
      sat_seen = 0;
      p = int'(rq.point_index);
      w = sx(rq.weight);
      v = sx(rq.value_term);
      gx = sx(rq.first_x);
      gy = sx(rq.first_y);
      hxx = sx(rq.second_xx);
      hxy = sx(rq.second_xy);
      hyy = sx(rq.second_yy);
      if (rq.req_type == rbd_pkg::ReqLoad) begin
        if (v <= 0) begin
          a.status = rbd_pkg::StatusBadQ;
        end else begin
          inv = clamp((64'sd4294967296 + v / 2) / v);
          inv2 = qmul(inv, inv);
          two_inv = clamp(2 * inv);
          s_x = qmul(inv2, gx);
          s_y = qmul(inv2, gy);
          inv_q[p] = inv[31:0];
          grad_sx[p] = s_x[31:0];
          grad_sy[p] = s_y[31:0];
          t = clamp(qmul(qmul(s_x, gx), two_inv) - qmul(hxx, inv2));
          term_xx[p] = t[31:0];
          // mixed term uses the x gradient term times dQ_y
          t = clamp(qmul(qmul(s_x, gy), two_inv) - qmul(hxy, inv2));
          term_xy[p] = t[31:0];
          t = clamp(qmul(qmul(s_y, gy), two_inv) - qmul(hyy, inv2));
          term_yy[p] = t[31:0];
          loaded[p] = 1;
          a.status = sat_seen ? rbd_pkg::StatusSat : rbd_pkg::StatusOk;
        end
      end else if (!loaded[p]) begin
        a.status = rbd_pkg::StatusNoPt;
      end else begin
        inv = sx(inv_q[p]);
        s_x = sx(grad_sx[p]);
        s_y = sx(grad_sy[p]);
        t = qmul(qmul(v, inv), w);
        a.rational_value = t[31:0];
        t = qmul(clamp(qmul(gx, inv) - qmul(v, s_x)), w);
        a.rational_dx = t[31:0];
        t = qmul(clamp(qmul(gy, inv) - qmul(v, s_y)), w);
        a.rational_dy = t[31:0];
        t = qmul(clamp(qmul(hxx, inv) - 2 * qmul(gx, s_x) + qmul(v, sx(term_xx[p]))), w);
        a.rational_dxx = t[31:0];
        t = qmul(clamp(qmul(hxy, inv) - qmul(gx, s_y) - qmul(gy, s_x)
                       + qmul(v, sx(term_xy[p]))), w);
        a.rational_dxy = t[31:0];
        t = qmul(clamp(qmul(hyy, inv) - 2 * qmul(gy, s_y) + qmul(v, sx(term_yy[p]))), w);
        a.rational_dyy = t[31:0];
        a.status = sat_seen ? rbd_pkg::StatusSat : rbd_pkg::StatusOk;
      end
      pending_answers.push_back(a);
    endfunction

    function void check_answer(answer_t got);
      answer_t exp_a;
      if (pending_answers.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result beat %h", got);
        return;
      end
      exp_a = pending_answers.pop_front();
      if (got !== exp_a) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("result mismatch: expected val %h dx %h dy %h dxx %h dxy %h dyy %h st %0d,",
                   exp_a.rational_value, exp_a.rational_dx, exp_a.rational_dy,
                   exp_a.rational_dxx, exp_a.rational_dxy, exp_a.rational_dyy, exp_a.status,
                   " got val %h dx %h dy %h dxx %h dxy %h dyy %h st %0d",
                   got.rational_value, got.rational_dx, got.rational_dy,
                   got.rational_dxx, got.rational_dxy, got.rational_dyy, got.status);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rbd_in_if  req_ch ();
  rbd_out_if res_ch ();

  rational_basis_derivative_eval dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (req_ch.sink),
    .out_if (res_ch.source)
  );

  always #6 clk_i = ~clk_i;

  rational_scoreboard board;
  bit  idle_free;      // final part of the run: no idling
  bit  hold_sink;      // long back-pressure stretch requested
  int  quiet_cycles;

  // ----- request driving -----
  task automatic send_request(request_t rq);
    int gap;
    if (!idle_free && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= rq.req_type;
    req_ch.point_index <= rq.point_index;
    req_ch.weight      <= rq.weight;
    req_ch.value_term  <= rq.value_term;
    req_ch.first_x     <= rq.first_x;
    req_ch.first_y     <= rq.first_y;
    req_ch.second_xx   <= rq.second_xx;
    req_ch.second_xy   <= rq.second_xy;
    req_ch.second_yy   <= rq.second_yy;
    // accepted at the rising edge where ready is high
    do @(posedge clk_i); while (!req_ch.ready);
    board.note_request(rq);
    @(negedge clk_i);
  endtask

  task automatic release_bus();
    req_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // random value with edge values mixed in
  function automatic logic [31:0] pick_field();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3, 4: return $urandom_range(0, 32'h3ffff) - 32'h1ffff;   // near unity
      default: return $urandom();
    endcase
  endfunction

  // well-formed q: positive, mostly moderate so results stay in range
  function automatic logic [31:0] pick_q();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h1;
      2: return $urandom_range(1, 32'h7fffffff);
      default: return $urandom_range(32'h4000, 32'h40000);
    endcase
  endfunction

  function automatic request_t make_load(int p);
    request_t rq;
    rq.req_type = rbd_pkg::ReqLoad;
    rq.point_index = 6'(p);
    rq.weight = $urandom();
    rq.value_term = pick_q();
    rq.first_x = pick_field();
    rq.first_y = pick_field();
    rq.second_xx = pick_field();
    rq.second_xy = pick_field();
    rq.second_yy = pick_field();
    return rq;
  endfunction

  function automatic request_t make_eval(int p);
    request_t rq;
    rq = make_load(p);
    rq.req_type = rbd_pkg::ReqEval;
    rq.weight = pick_field();
    rq.value_term = pick_field();
    return rq;
  endfunction

  // ----- result side: random stalls, long hold on request -----
  initial begin
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_sink) begin
        res_ch.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_sink = 0;
        res_ch.ready <= 1'b1;
      end else if (!idle_free && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(negedge clk_i);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    answer_t got;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got = {res_ch.rational_value, res_ch.rational_dx, res_ch.rational_dy,
             res_ch.rational_dxx, res_ch.rational_dxy, res_ch.rational_dyy, res_ch.status};
      board.check_answer(got);
    end
  end

  // watchdog: cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // ----- stimulus -----
  initial begin
    request_t rq;
    int p;
    board = new();
    board.clear();
    quiet_cycles = 0;
    req_ch.valid = 1'b0;
    req_ch.req_type = rbd_pkg::ReqLoad;
    req_ch.point_index = '0;
    req_ch.weight = '0;
    req_ch.value_term = '0;
    req_ch.first_x = '0;
    req_ch.first_y = '0;
    req_ch.second_xx = '0;
    req_ch.second_xy = '0;
    req_ch.second_yy = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: evaluate before load, bad q, unity q, extremes
    rq = make_eval(0);
    send_request(rq);                              // point never loaded
    rq = make_load(0);
    rq.value_term = 32'h0;
    send_request(rq);                              // q zero rejected
    rq.value_term = 32'h80000000;
    send_request(rq);                              // most negative q rejected
    rq = '{rbd_pkg::ReqLoad, 6'd0, 32'h0, 32'h10000, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0};
    send_request(rq);                              // q = 1, flat
    rq = '{rbd_pkg::ReqEval, 6'd0, 32'h10000, 32'h8000, 32'h1000, 32'hfffff000,
           32'h100, 32'h200, 32'h300};
    send_request(rq);
    rq = '{rbd_pkg::ReqLoad, 6'd63, 32'hffffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
           32'h7fffffff, 32'h80000000, 32'h7fffffff};
    send_request(rq);                              // largest q
    rq = '{rbd_pkg::ReqLoad, 6'd1, 32'h0, 32'h1, 32'h7fffffff, 32'h7fffffff,
           32'h80000000, 32'h7fffffff, 32'h80000000};
    send_request(rq);                              // tiny q saturates on load
    rq = '{rbd_pkg::ReqEval, 6'd1, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
           32'h80000000, 32'h7fffffff, 32'h80000000};
    send_request(rq);                              // saturating evaluate
    rq = '{rbd_pkg::ReqEval, 6'd63, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
           32'h7fffffff, 32'h80000000, 32'h7fffffff};
    send_request(rq);
    rq = '{rbd_pkg::ReqLoad, 6'd2, 32'h0, 32'h20000, 32'h8000, 32'h4000,
           32'h1000, 32'h2000, 32'h3000};
    send_request(rq);
    rq = '{rbd_pkg::ReqEval, 6'd2, 32'hfffe0000, 32'h18000, 32'h4000, 32'hffffc000,
           32'h800, 32'hfffff800, 32'h400};
    send_request(rq);                              // mixed term with distinct gradients
    rq = make_eval(62);
    send_request(rq);                              // still unloaded

    // pause until the block drains
    release_bus();
    while (board.pending_answers.size() != 0) @(negedge clk_i);

    // hold the result side while requests keep coming
    hold_sink = 1;
    for (int i = 0; i < 40; i++) begin
      p = $urandom_range(0, 7);
      send_request($urandom_range(0, 1) ? make_load(p) : make_eval(p));
    end

    // random part: loads, negative-q loads and mostly evaluates over all 64 points
    for (int i = 0; i < 1100; i++) begin
      if (i == 950) idle_free = 1;
      p = $urandom_range(0, 63);
      case ($urandom_range(0, 9))
        0, 1, 2: rq = make_load(p);
        3: begin
          rq = make_load(p);
          rq.value_term = $urandom() | 32'h80000000;  // negative q
        end
        default: rq = make_eval(p);
      endcase
      // unloaded reads are legal: flags are clear, status 2
      send_request(rq);
    end
    release_bus();

    while (board.pending_answers.size() != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (board.mismatch_cnt == 0 && board.pending_answers.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
